[hdl/assert_macros.svh]
// Assertion macros of the band feature meter, used by afbf_back.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is active
`define ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
// Clocked check that also holds during reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) (prop)) else $error(msg);
`else
`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hdl/afbf_pkg.sv]
// Package of the audio band feature meter: widths, limits, register codes and types.
// Used by every module of the block; depends on nothing.
package afbf_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int GSUM_W      = 19;
    localparam int CNT_W       = 13;
    localparam int SUM_W       = 44;
    localparam int ROOT_W      = 22;
    localparam int MAX_FRAME   = 4096;
    localparam int MAX_CH      = 8;

    localparam logic [15:0] LP_MIN  = 16'd66;
    localparam logic [15:0] LP_MAX  = 16'd58982;
    localparam logic [15:0] HP_MIN  = 16'd655;
    localparam logic [15:0] HP_MAX  = 16'd58982;

    // Configuration register indexes
    localparam logic [1:0] REG_SENS    = 2'd0;
    localparam logic [1:0] REG_BASS    = 2'd1;
    localparam logic [1:0] REG_TREBLE  = 2'd2;
    localparam logic [1:0] REG_CHANNEL = 2'd3;

    localparam logic [15:0] SENS_RST    = 16'd10240;
    localparam logic [15:0] BASS_RST    = 16'd328;
    localparam logic [15:0] TREBLE_RST  = 16'd19661;
    localparam logic [3:0]  CHANNEL_RST = 4'd1;

    // Settings as the datapath uses them; bass, treble and channel count are clamped
    typedef struct packed {
        logic [15:0] sens;
        logic [15:0] lp_alpha;
        logic [15:0] hp_alpha;
        logic [3:0]  ch_n;
    } cfg_t;

    // One closed channel group, as queued between front and back
    typedef struct packed {
        logic signed [GSUM_W-1:0] sum;
        logic [3:0]               n;
        logic                     last;
    } grp_t;

endpackage

[hdl/afbf_front.sv]
// Front end: configuration registers, sample intake and channel-group summing.
// Depends on afbf_pkg; pushes closed groups into the queue.
module afbf_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // [15:0] sample
    input  logic                  s_tlast,   // frame_end
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output afbf_pkg::cfg_t        cfg_o,
    input  logic                  q_full,
    output logic                  q_push,
    output afbf_pkg::grp_t        q_data
);

    logic [15:0] sens_reg, bass_reg, treble_reg;
    logic [3:0]  chan_reg;
    logic signed [afbf_pkg::GSUM_W-1:0] gsum_reg, gsum_next;
    logic [3:0]  pos_reg, pos_next;
    logic        beat, close;
    logic [15:0] hp_c;
    logic [16:0] hp_a;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign beat      = s_tvalid && s_tready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sens_reg   <= afbf_pkg::SENS_RST;
            bass_reg   <= afbf_pkg::BASS_RST;
            treble_reg <= afbf_pkg::TREBLE_RST;
            chan_reg   <= afbf_pkg::CHANNEL_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                afbf_pkg::REG_SENS:    sens_reg   <= cfg_data;
                afbf_pkg::REG_BASS:    bass_reg   <= cfg_data;
                afbf_pkg::REG_TREBLE:  treble_reg <= cfg_data;
                afbf_pkg::REG_CHANNEL: chan_reg   <= cfg_data[3:0];
                default:               sens_reg   <= sens_reg;
            endcase
        end
    end

    // Clamp settings to their usable ranges; sens passes through unclamped
    always_comb begin
        cfg_o.sens = sens_reg;
        if (bass_reg < afbf_pkg::LP_MIN)      cfg_o.lp_alpha = afbf_pkg::LP_MIN;
        else if (bass_reg > afbf_pkg::LP_MAX) cfg_o.lp_alpha = afbf_pkg::LP_MAX;
        else                                  cfg_o.lp_alpha = bass_reg;
        if (treble_reg < afbf_pkg::HP_MIN)      hp_c = afbf_pkg::HP_MIN;
        else if (treble_reg > afbf_pkg::HP_MAX) hp_c = afbf_pkg::HP_MAX;
        else                                    hp_c = treble_reg;
        hp_a = 17'h10000 - {1'b0, hp_c};
        cfg_o.hp_alpha = hp_a[15:0];
        if (chan_reg == 4'd0)                       cfg_o.ch_n = 4'd1;
        else if (chan_reg > 4'(afbf_pkg::MAX_CH))   cfg_o.ch_n = 4'(afbf_pkg::MAX_CH);
        else                                        cfg_o.ch_n = chan_reg;
    end

    // Group summing; a group closes on count or at frame end
    always_comb begin
        gsum_next = gsum_reg + {{(afbf_pkg::GSUM_W-16){s_tdata[15]}}, s_tdata};
        pos_next  = pos_reg + 4'd1;
        close     = (pos_next >= cfg_o.ch_n) || s_tlast;
        q_push    = beat && close;
        q_data.sum  = gsum_next;
        q_data.n    = cfg_o.ch_n;
        q_data.last = s_tlast;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gsum_reg <= '0;
            pos_reg  <= '0;
        end else if (beat) begin
            gsum_reg <= close ? '0 : gsum_next;
            pos_reg  <= close ? '0 : pos_next;
        end
    end

endmodule

[hdl/afbf_fifo.sv]
// Four-entry queue of closed channel groups between front and back.
// Depends on afbf_pkg for the entry type.
module afbf_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  afbf_pkg::grp_t  push_data,
    input  logic            pop,
    output afbf_pkg::grp_t  pop_data,
    output logic            full,
    output logic            empty
);

    afbf_pkg::grp_t mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = (cnt_reg == 3'd4);
    assign empty    = (cnt_reg == 3'd0);
    assign pop_data = mem_reg[rp_reg];

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop)  rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_reg + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

[hdl/afbf_div.sv]
// Restoring divider, one quotient bit per cycle, shared for group and frame divides.
// Depends on afbf_pkg for widths.
module afbf_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic                         short_op,  // dividend fits the group-sum width
    input  logic [afbf_pkg::SUM_W-1:0]   dividend,
    input  logic [afbf_pkg::CNT_W-1:0]   divisor,
    output logic                         done,
    output logic [afbf_pkg::SUM_W-1:0]   quotient
);

    localparam int PAD = afbf_pkg::SUM_W - afbf_pkg::GSUM_W;

    logic [afbf_pkg::SUM_W-1:0] dvd_reg, quo_reg;
    logic [afbf_pkg::CNT_W-1:0] rem_reg, dsr_reg;
    logic [5:0]                 cnt_reg;
    logic                       busy_reg, done_reg;
    logic [afbf_pkg::CNT_W:0]   rem_sh, rem_sub;
    logic                       ge;

    assign done     = done_reg;
    assign quotient = quo_reg;

    // One trial subtraction
    always_comb begin
        rem_sh  = {rem_reg, dvd_reg[afbf_pkg::SUM_W-1]};
        ge      = rem_sh >= {1'b0, dsr_reg};
        rem_sub = rem_sh - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= short_op ? 6'(afbf_pkg::GSUM_W) : 6'(afbf_pkg::SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= short_op ? {dividend[afbf_pkg::GSUM_W-1:0], PAD'(0)} : dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[afbf_pkg::SUM_W-2:0], 1'b0};
            rem_reg <= ge ? rem_sub[afbf_pkg::CNT_W-1:0] : rem_sh[afbf_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[afbf_pkg::SUM_W-2:0], ge};
        end
    end

endmodule

[hdl/afbf_isqrt.sv]
// Floor square root, one root bit per cycle over the 44-bit mean square.
// Depends on afbf_pkg for widths.
module afbf_isqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [afbf_pkg::SUM_W-1:0]    radicand,
    output logic                          done,
    output logic [afbf_pkg::ROOT_W-1:0]   root
);

    logic [afbf_pkg::SUM_W-1:0]  rad_reg;
    logic [24:0]                 rem_reg;
    logic [afbf_pkg::ROOT_W-1:0] root_reg;
    logic [4:0]                  cnt_reg;
    logic                        busy_reg, done_reg;
    logic [26:0]                 rem_sh, trial, rem_sub;
    logic                        ge;

    assign done = done_reg;
    assign root = root_reg;

    // Trial subtract of 4*root+1
    always_comb begin
        rem_sh  = {rem_reg, rad_reg[afbf_pkg::SUM_W-1 -: 2]};
        trial   = {3'b0, root_reg, 2'b01};
        ge      = rem_sh >= trial;
        rem_sub = rem_sh - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'(afbf_pkg::ROOT_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[afbf_pkg::SUM_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[24:0] : rem_sh[24:0];
            root_reg <= {root_reg[afbf_pkg::ROOT_W-2:0], ge};
        end
    end

endmodule

[hdl/afbf_back.sv]
// Back end: mono divide, filters, square sums, and frame-end RMS and scaling.
// Depends on afbf_pkg, afbf_div, afbf_isqrt and assert_macros.svh.
`include "assert_macros.svh"
module afbf_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  afbf_pkg::cfg_t        cfg,
    input  logic                  q_empty,
    input  afbf_pkg::grp_t        q_data,
    output logic                  q_pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [95:0]           m_tdata
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_MDIV   = 4'd1;
    localparam logic [3:0] ST_MUL1   = 4'd2;
    localparam logic [3:0] ST_MUL2   = 4'd3;
    localparam logic [3:0] ST_MUL3   = 4'd4;
    localparam logic [3:0] ST_ACC    = 4'd5;
    localparam logic [3:0] ST_FSTART = 4'd6;
    localparam logic [3:0] ST_FDIV   = 4'd7;
    localparam logic [3:0] ST_SQRT   = 4'd8;
    localparam logic [3:0] ST_SCALE  = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam int SW = afbf_pkg::SUM_W;
    localparam int RW = afbf_pkg::ROOT_W;
    localparam logic [SW-1:0] SUM_MAX = {SW{1'b1}};
    localparam logic [afbf_pkg::CNT_W-1:0] CNT_MAX = afbf_pkg::CNT_W'(afbf_pkg::MAX_FRAME);

    logic [3:0]              state_reg;
    afbf_pkg::grp_t          ent_reg;
    logic signed [15:0]      x_reg, hpx_reg;
    logic signed [23:0]      lp_reg, hpy_reg;
    logic [31:0]             sq_reg, bsq_reg;
    logic [32:0]             tsq_reg;
    logic signed [41:0]      lpp_reg, hpp_reg;
    logic [SW-1:0]           ssum_reg, bsum_reg, tsum_reg;
    logic [15:0]             peak_reg;
    logic [afbf_pkg::CNT_W-1:0] cnt_reg;
    logic [1:0]              fin_reg;
    logic [RW-1:0]           rms_reg [3];
    logic [37:0]             prod_reg [6];
    logic                    mval_reg;
    logic [95:0]             mdat_reg;

    logic                    div_start, div_short, div_done;
    logic [SW-1:0]           div_dvd, div_q;
    logic [afbf_pkg::CNT_W-1:0] div_dsr;
    logic                    sq_start, sq_done;
    logic [SW-1:0]           sq_rad;
    logic [RW-1:0]           sq_root;
    logic [19:0]             abs_sum;
    logic                    out_load;
    logic                    issue_st, wait_st;

    logic signed [16:0]      x_mono;
    logic [16:0]             mag;
    logic signed [24:0]      lp_diff, hp_sum;
    logic signed [16:0]      hp_dx;
    logic signed [25:0]      lp_new;
    logic signed [25:0]      hp_y26;
    logic signed [23:0]      hp_sat;
    logic signed [31:0]      lsq;
    logic signed [33:0]      tsq;
    logic signed [16:0]      q_hp;
    logic signed [22:0]      v_vol, v_mid, v_dr, v_pk;
    logic [RW:0]             bt_sum;
    logic [RW-1:0]           pos_v [6];
    logic [SW-1:0]           fsum;

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;

    function automatic logic [SW-1:0] sat_add(logic [SW-1:0] a, logic [32:0] b);
        logic [SW:0] s;
        s = {1'b0, a} + {{(SW-32){1'b0}}, b};
        return s[SW] ? SUM_MAX : s[SW-1:0];
    endfunction

    function automatic logic [RW-1:0] pos_part(logic signed [22:0] v);
        return v[22] ? '0 : v[RW-1:0];
    endfunction

    function automatic logic [15:0] sat16(logic [37:0] p);
        return (|p[37:27]) ? 16'hFFFF : p[26:11];
    endfunction

    afbf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .short_op (div_short),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .done     (div_done),
        .quotient (div_q)
    );

    afbf_isqrt u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Shared unit control and datapath terms
    always_comb begin
        abs_sum   = q_data.sum[18] ? (20'd0 - {q_data.sum[18], q_data.sum})
                                   : {1'b0, q_data.sum};
        q_pop     = (state_reg == ST_IDLE) && !q_empty;
        unique case (fin_reg)
            2'd0:    fsum = ssum_reg;
            2'd1:    fsum = bsum_reg;
            default: fsum = tsum_reg;
        endcase
        div_start = q_pop || (state_reg == ST_FSTART);
        div_short = q_pop;
        div_dvd   = q_pop ? {{(SW-20){1'b0}}, abs_sum} : fsum;
        div_dsr   = q_pop ? {{(afbf_pkg::CNT_W-4){1'b0}}, q_data.n} : cnt_reg;
        sq_start  = (state_reg == ST_FDIV) && div_done;
        sq_rad    = (cnt_reg == '0) ? '0 : div_q;
        issue_st  = (state_reg == ST_IDLE) || (state_reg == ST_FSTART);
        wait_st   = (state_reg == ST_MDIV) || (state_reg == ST_FDIV);

        x_mono  = ent_reg.sum[18] ? (17'sd0 - $signed(div_q[16:0])) : $signed(div_q[16:0]);
        mag     = x_reg[15] ? (17'd0 - {x_reg[15], x_reg}) : {1'b0, x_reg};
        lp_diff = $signed({x_reg[15], x_reg, 8'b0}) - $signed({lp_reg[23], lp_reg});
        hp_dx   = $signed({x_reg[15], x_reg}) - $signed({hpx_reg[15], hpx_reg});
        hp_sum  = $signed({hpy_reg[23], hpy_reg}) + $signed({hp_dx[16], hp_dx, 7'b0});
        lp_new  = $signed({{2{lp_reg[23]}}, lp_reg}) + lpp_reg[41:16];
        hp_y26  = hpp_reg[41:16];
        if (hp_y26 > 26'sd8388607)       hp_sat = 24'sh7FFFFF;
        else if (hp_y26 < -26'sd8388608) hp_sat = 24'sh800000;
        else                             hp_sat = hp_y26[23:0];
        lsq     = $signed(lp_reg[23:8]) * $signed(lp_reg[23:8]);
        q_hp    = hpy_reg[23:7];
        tsq     = q_hp * q_hp;

        v_vol  = {1'b0, rms_reg[0]};
        v_pk   = {7'b0, peak_reg};
        bt_sum = {1'b0, rms_reg[1]} + {1'b0, rms_reg[2]};
        v_mid  = v_vol - {1'b0, bt_sum[RW:1]};
        v_dr   = v_pk - v_vol;
        pos_v[0] = rms_reg[0];
        pos_v[1] = rms_reg[1];
        pos_v[2] = pos_part(v_mid);
        pos_v[3] = rms_reg[2];
        pos_v[4] = {6'b0, peak_reg};
        pos_v[5] = pos_part(v_dr);
        out_load = (state_reg == ST_OUT) && (!mval_reg || m_tready);
    end

    // Sequencer and per-sample datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= '0;
            lp_reg    <= '0;
            hpx_reg   <= '0;
            hpy_reg   <= '0;
            ssum_reg  <= '0;
            bsum_reg  <= '0;
            tsum_reg  <= '0;
            peak_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (!q_empty) begin
                        ent_reg   <= q_data;
                        state_reg <= ST_MDIV;
                    end
                end
                ST_MDIV: begin
                    if (div_done) begin
                        x_reg     <= x_mono[15:0];
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    sq_reg  <= 32'(x_reg * x_reg);
                    lpp_reg <= $signed({1'b0, cfg.lp_alpha}) * lp_diff;
                    hpp_reg <= $signed({1'b0, cfg.hp_alpha}) * hp_sum;
                    hpx_reg <= x_reg;
                    if (mag[15:0] > peak_reg) peak_reg <= mag[15:0];
                    if (cnt_reg < CNT_MAX)
                        cnt_reg <= cnt_reg + 1'b1;
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    lp_reg    <= lp_new[23:0];
                    hpy_reg   <= hp_sat;
                    ssum_reg  <= sat_add(ssum_reg, {1'b0, sq_reg});
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    bsq_reg   <= lsq;
                    tsq_reg   <= tsq[32:0];
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    bsum_reg  <= sat_add(bsum_reg, {1'b0, bsq_reg});
                    tsum_reg  <= sat_add(tsum_reg, tsq_reg);
                    fin_reg   <= '0;
                    state_reg <= ent_reg.last ? ST_FSTART : ST_IDLE;
                end
                ST_FSTART: state_reg <= ST_FDIV;
                ST_FDIV: begin
                    if (div_done) state_reg <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sq_done) begin
                        rms_reg[fin_reg] <= sq_root;
                        if (fin_reg == 2'd2) begin
                            state_reg <= ST_SCALE;
                        end else begin
                            fin_reg   <= fin_reg + 2'd1;
                            state_reg <= ST_FSTART;
                        end
                    end
                end
                ST_SCALE: begin
                    for (int i = 0; i < 6; i++) begin
                        prod_reg[i] <= pos_v[i] * cfg.sens;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        ssum_reg  <= '0;
                        bsum_reg  <= '0;
                        tsum_reg  <= '0;
                        peak_reg  <= '0;
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mval_reg <= 1'b0;
        end else if (out_load) begin
            mval_reg <= 1'b1;
        end else if (m_tready) begin
            mval_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            mdat_reg <= {sat16(prod_reg[5]), sat16(prod_reg[4]), sat16(prod_reg[3]),
                         sat16(prod_reg[2]), sat16(prod_reg[1]), sat16(prod_reg[0])};
        end
    end

    `ASSERT_RST(a_div_start_state, div_start |-> issue_st, "divider started out of turn")
    `ASSERT_RST(a_div_done_state, div_done |-> wait_st, "divider done while not waiting")
    `ASSERT_RST(a_sqrt_done_state, sq_done |-> (state_reg == ST_SQRT), "root done while not waiting")
    `ASSERT_RST(a_fin_bound, (state_reg == ST_SQRT) |-> (fin_reg <= 2'd2), "finalize index too high")
    `ASSERT_ALWAYS(a_cnt_bound, !aresetn || cnt_reg <= CNT_MAX, "sample count beyond frame limit")

endmodule

[hdl/audio_frame_band_features_top.sv]
// Top level of the audio frame band feature meter.
// Depends on afbf_pkg, afbf_front, afbf_fifo and afbf_back.

// Samples are taken one per cycle while the four-entry group queue has room; the back end
// takes one closed channel group at a time through an issue step, a serial 19-bit mono
// divide whose quotient is then taken, and four filter/accumulate steps. A frame end adds
// three passes, each a 44-bit divide and then a 22-bit square root, run in turn on one
// divider and one root unit, then scaling and output. A frame's result is held in an output
// register while the next frame is taken in. Filter state persists across frames; sums,
// peak and count clear after each result.
module audio_frame_band_features_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // [15:0] sample
    input  logic         s_tlast,   // frame_end
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] volume, [31:16] bass, [47:32] midrange, [63:48] treble,
    // [79:64] peak_level, [95:80] dyn_range
    output logic [95:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data
);

    afbf_pkg::cfg_t cfg;
    afbf_pkg::grp_t push_data, pop_data;
    logic           push, pop, full, empty;

    afbf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_o     (cfg),
        .q_full    (full),
        .q_push    (push),
        .q_data    (push_data)
    );

    afbf_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (full),
        .empty     (empty)
    );

    afbf_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_empty   (empty),
        .q_data    (pop_data),
        .q_pop     (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
